FILE: rtl/rvx_pkg.sv
`timescale 1ns / 1ps
package rvx_pkg;

	localparam int XLEN     = 32;
	localparam int NUM_REGS = 32;
	localparam int REG_AW   = $clog2(NUM_REGS);

	// major opcodes
	localparam logic [6:0] OPC_LOAD     = 7'd3;
	localparam logic [6:0] OPC_MISC_MEM = 7'd15;
	localparam logic [6:0] OPC_OP_IMM   = 7'd19;
	localparam logic [6:0] OPC_AUIPC    = 7'd23;
	localparam logic [6:0] OPC_STORE    = 7'd35;
	localparam logic [6:0] OPC_OP       = 7'd51;
	localparam logic [6:0] OPC_LUI      = 7'd55;
	localparam logic [6:0] OPC_BRANCH   = 7'd99;
	localparam logic [6:0] OPC_SYSTEM   = 7'd115;

	// funct3 codes
	localparam logic [2:0] F3_ADDI = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLTI = 3'd2;
	localparam logic [2:0] F3_SLTIU = 3'd3;
	localparam logic [2:0] F3_XORI = 3'd4;
	localparam logic [2:0] F3_ORI  = 3'd6;
	localparam logic [2:0] F3_ANDI = 3'd7;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;
	localparam logic [2:0] F3_LD   = 3'd3;
	localparam logic [2:0] F3_LBU6 = 3'd6;
	localparam logic [2:0] F3_LBU7 = 3'd7;
	localparam logic [2:0] F3_SW   = 3'd2;
	localparam logic [2:0] F3_FENCEI = 3'd1;
	localparam logic [2:0] F3_SYS4 = 3'd4;

	typedef struct packed {
		logic [XLEN-1:0]   next_pc;
		logic              illegal;
		logic              wrote_reg;
		logic [REG_AW-1:0] dest_index;
		logic [XLEN-1:0]   dest_value;
		logic              branch_taken;
	} result_t;

	// sign-extend a 12-bit immediate to the word width
	function automatic logic [XLEN-1:0] sext12(input logic [11:0] v);
		sext12 = {{(XLEN-12){v[11]}}, v};
	endfunction

endpackage

FILE: rtl/rvx_if.sv
`timescale 1ns / 1ps
interface rvx_instr_if;
	import rvx_pkg::*;
	logic            valid;
	logic            ready;
	logic [XLEN-1:0] instruction;
	modport source(output valid, output instruction, input ready);
	modport sink(input valid, input instruction, output ready);
endinterface

interface rvx_result_if;
	import rvx_pkg::*;
	logic              valid;
	logic              ready;
	logic [XLEN-1:0]   next_pc;
	logic              illegal;
	logic              wrote_reg;
	logic [REG_AW-1:0] dest_index;
	logic [XLEN-1:0]   dest_value;
	logic              branch_taken;
	modport source(output valid, output next_pc, output illegal, output wrote_reg,
		output dest_index, output dest_value, output branch_taken, input ready);
	modport sink(input valid, input next_pc, input illegal, input wrote_reg,
		input dest_index, input dest_value, input branch_taken, output ready);
endinterface

FILE: rtl/rvx_alu.sv
`timescale 1ns / 1ps
module rvx_alu (
	input  logic [rvx_pkg::XLEN-1:0] instruction,
	input  logic [rvx_pkg::XLEN-1:0] pc,
	input  logic [rvx_pkg::XLEN-1:0] a,
	input  logic [rvx_pkg::XLEN-1:0] b,
	output rvx_pkg::result_t         res
);
	import rvx_pkg::*;

	logic [6:0]        opc;
	logic [2:0]        f3;
	logic [REG_AW-1:0] rd;
	logic [XLEN-1:0]   imm;
	logic [XLEN-1:0]   boff;
	logic [XLEN-1:0]   seq_pc;
	logic              bad;
	logic              wr;
	logic              taken;
	logic [XLEN-1:0]   val;
	logic              lt_ab;
	logic              lt_ai;
	logic              ltu_ab;

	// field split and immediates
	assign opc    = instruction[6:0];
	assign f3     = instruction[14:12];
	assign rd     = instruction[11:7];
	assign imm    = sext12(instruction[31:20]);
	assign boff   = sext12({instruction[31:25], instruction[11:7]});
	assign seq_pc = pc + XLEN'(1);
	assign lt_ab  = $signed(a) < $signed(b);
	assign lt_ai  = $signed(a) < $signed(imm);
	assign ltu_ab = a < b;

	// decode and execute
	always_comb begin
		bad   = 1'b0;
		wr    = 1'b0;
		taken = 1'b0;
		val   = '0;
		case (opc)
			OPC_LOAD: begin
				bad = (f3 == F3_LD) || (f3 == F3_LBU6) || (f3 == F3_LBU7);
			end
			OPC_STORE: begin
				bad = f3 > F3_SW;
			end
			OPC_MISC_MEM: begin
				bad = f3 > F3_FENCEI;
			end
			OPC_SYSTEM: begin
				bad = f3 == F3_SYS4;
			end
			OPC_AUIPC: begin
				bad = 1'b0;
			end
			OPC_LUI: begin
				wr  = 1'b1;
				val = {instruction[31:12], 12'd0};
			end
			OPC_OP_IMM: begin
				case (f3)
					F3_ADDI: begin
						wr  = 1'b1;
						val = a + imm;
					end
					F3_SLTI: begin
						wr  = 1'b1;
						val = {{(XLEN-1){1'b0}}, lt_ai};
					end
					F3_SLTIU: begin
						wr = 1'b0;
					end
					F3_XORI: begin
						wr  = 1'b1;
						val = a ^ imm;
					end
					F3_ORI: begin
						wr  = 1'b1;
						val = a | imm;
					end
					F3_ANDI: begin
						wr  = 1'b1;
						val = a & imm;
					end
					default: begin
						bad = 1'b1;
					end
				endcase
			end
			OPC_OP: begin
				if (f3 == F3_SLL) begin
					wr  = 1'b1;
					val = a << b[4:0];
				end else if (f3 == F3_SLTI) begin
					wr  = 1'b1;
					val = {{(XLEN-1){1'b0}}, lt_ab};
				end
			end
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ:  taken = a == b;
					F3_BNE:  taken = a != b;
					F3_BLT:  taken = lt_ab;
					F3_BGE:  taken = !lt_ab;
					F3_BLTU: taken = ltu_ab;
					F3_BGEU: taken = !ltu_ab;
					default: bad = 1'b1;
				endcase
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// result assembly, writes to x0 are dropped
	always_comb begin
		res              = '0;
		res.illegal      = bad;
		res.wrote_reg    = !bad && wr && (rd != '0);
		res.branch_taken = !bad && taken;
		res.dest_index   = res.wrote_reg ? rd : '0;
		res.dest_value   = res.wrote_reg ? val : '0;
		if (bad) begin
			res.next_pc = pc;
		end else if (taken) begin
			res.next_pc = pc + boff;
		end else begin
			res.next_pc = seq_pc;
		end
	end

endmodule

FILE: rtl/rv32i_subset_executor.sv
`timescale 1ns / 1ps
// instruction beat to result beat: operand read into the s1 registers, then execute into res_q
// throughput: one instruction per cycle unless result.ready stalls it; a result writes
// the register file when it is registered, and the following instruction takes it by bypass
// reset: pc and all registers read as zero (per-register valid bits), pipeline empty
module rv32i_subset_executor (
	input logic           clk,
	input logic           arst_n,
	rvx_instr_if.sink     instr,
	rvx_result_if.source  result
);
	import rvx_pkg::*;

	logic [XLEN-1:0]     rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [XLEN-1:0]     pc_q;

	logic                vld_s1;
	logic [XLEN-1:0]     instr_s1;
	logic [XLEN-1:0]     a_raw_s1;
	logic [XLEN-1:0]     b_raw_s1;
	logic [XLEN-1:0]     fwd_s1;
	logic                a_hit_s1;
	logic                b_hit_s1;
	logic                a_zero_s1;
	logic                b_zero_s1;

	logic                out_vld_q;
	result_t             res_q;

	logic                in_acc;
	logic                ex_fire;
	logic [REG_AW-1:0]   rs1;
	logic [REG_AW-1:0]   rs2;
	logic                a_hit;
	logic                b_hit;
	logic [XLEN-1:0]     a_op;
	logic [XLEN-1:0]     b_op;
	result_t             ex_res;

	// handshake
	assign ex_fire     = vld_s1 && (!out_vld_q || result.ready);
	assign instr.ready = !vld_s1 || ex_fire;
	assign in_acc      = instr.valid && instr.ready;

	assign rs1   = instr.instruction[19:15];
	assign rs2   = instr.instruction[24:20];
	assign a_hit = ex_fire && ex_res.wrote_reg && (ex_res.dest_index == rs1);
	assign b_hit = ex_fire && ex_res.wrote_reg && (ex_res.dest_index == rs2);

	// register file memory, read at the instruction beat
	always_ff @(posedge clk) begin
		if (ex_fire && ex_res.wrote_reg) begin
			rf_mem[ex_res.dest_index] <= ex_res.dest_value;
		end
		if (in_acc) begin
			a_raw_s1 <= rf_mem[rs1];
			b_raw_s1 <= rf_mem[rs2];
		end
	end

	// operand stage payload and bypass flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1  <= instr.instruction;
			fwd_s1    <= ex_res.dest_value;
			a_hit_s1  <= a_hit;
			b_hit_s1  <= b_hit;
			a_zero_s1 <= (rs1 == '0) || (!a_hit && !rf_vld_q[rs1]);
			b_zero_s1 <= (rs2 == '0) || (!b_hit && !rf_vld_q[rs2]);
		end
	end

	// operand select
	always_comb begin
		if (a_zero_s1) begin
			a_op = '0;
		end else if (a_hit_s1) begin
			a_op = fwd_s1;
		end else begin
			a_op = a_raw_s1;
		end
		if (b_zero_s1) begin
			b_op = '0;
		end else if (b_hit_s1) begin
			b_op = fwd_s1;
		end else begin
			b_op = b_raw_s1;
		end
	end

	rvx_alu u_alu (
		.instruction (instr_s1),
		.pc          (pc_q),
		.a           (a_op),
		.b           (b_op),
		.res         (ex_res)
	);

	// control state: valid flags, pc, register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			pc_q      <= '0;
			rf_vld_q  <= '0;
		end else begin
			if (instr.ready) begin
				vld_s1 <= instr.valid;
			end
			if (ex_fire) begin
				out_vld_q <= 1'b1;
				pc_q      <= ex_res.next_pc;
				if (ex_res.wrote_reg) begin
					rf_vld_q[ex_res.dest_index] <= 1'b1;
				end
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ex_fire) begin
			res_q <= ex_res;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.next_pc      = res_q.next_pc;
	assign result.illegal      = res_q.illegal;
	assign result.wrote_reg    = res_q.wrote_reg;
	assign result.dest_index   = res_q.dest_index;
	assign result.dest_value   = res_q.dest_value;
	assign result.branch_taken = res_q.branch_taken;

endmodule
